/* design/rthp_pkg.sv */
// Package for the radiotap header parser.
// Holds the phase encoding, present-word sizes and the field size/alignment table.
// No dependencies.
`timescale 1ns / 1ps

package rthp_pkg;

  // Present words held per packet, with the index and count widths they imply.
  localparam int PRES_WORDS = 8;
  localparam int PW_IDX_W   = (PRES_WORDS > 1) ? $clog2(PRES_WORDS) : 1;
  localparam int PW_CNT_W   = $clog2(PRES_WORDS + 1);

  // Present bits 0 to 17 have a known size; a higher set bit ends the walk.
  localparam int KNOWN_BITS = 18;

  // Present bit numbers of the captured fields.
  localparam logic [4:0] BIT_FLAGS   = 5'd1;
  localparam logic [4:0] BIT_RATE    = 5'd2;
  localparam logic [4:0] BIT_CHANNEL = 5'd3;
  localparam logic [4:0] BIT_SIGNAL  = 5'd5;
  localparam logic [4:0] BIT_ANTENNA = 5'd11;

  // Parse phase, one-hot.
  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_PRESENT = 4'b0010,
    PH_FIELDS  = 4'b0100,
    PH_DONE    = 4'b1000
  } rthp_phase_t;

  // Pending present bits of each word; bit 31 is never walked.
  typedef logic [PRES_WORDS-1:0][30:0] rthp_pend_t;

  // Result of a search for the next field.
  typedef struct packed {
    logic                hit;
    logic [PW_IDX_W-1:0] word_idx;
    logic [4:0]          bit_idx;
    logic [15:0]         fbeg;
    logic [3:0]          fbytes;
  } rthp_seek_t;

  // Field size in bytes for a known present bit.
  function automatic logic [3:0] fld_size(input logic [4:0] b);
    logic [3:0] s;
    unique case (b)
      5'd0:                              s = 4'd8;
      5'd3:                              s = 4'd4;
      5'd4, 5'd7, 5'd8, 5'd9, 5'd14, 5'd15: s = 4'd2;
      default:                           s = 4'd1;
    endcase
    return s;
  endfunction

  // Field alignment in bytes for a known present bit.
  function automatic logic [3:0] fld_align(input logic [4:0] b);
    logic [3:0] a;
    unique case (b)
      5'd0:                                    a = 4'd8;
      5'd3, 5'd4, 5'd7, 5'd8, 5'd9, 5'd14, 5'd15: a = 4'd2;
      default:                                 a = 4'd1;
    endcase
    return a;
  endfunction

endpackage

/* design/rthp_if.sv */
// Stream interfaces for the radiotap header parser: byte input and result output.
// Depends on nothing; each carries valid, ready and its payload.
`timescale 1ns / 1ps

interface rthp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rthp_out_if;
  logic              valid;
  logic              ready;
  logic              parse_ok;
  logic [15:0]       header_len;
  logic [4:0]        found_mask;
  logic [7:0]        radio_flags;
  logic [7:0]        rate_units;
  logic [15:0]       chan_freq_mhz;
  logic [15:0]       chan_flag_bits;
  logic signed [7:0] signal_dbm;
  logic [7:0]        antenna_index;
  logic signed [8:0] channel_number;

  modport source (output valid, output parse_ok, output header_len, output found_mask,
                  output radio_flags, output rate_units, output chan_freq_mhz,
                  output chan_flag_bits, output signal_dbm, output antenna_index,
                  output channel_number, input ready);
  modport sink   (input valid, input parse_ok, input header_len, input found_mask,
                  input radio_flags, input rate_units, input chan_freq_mhz,
                  input chan_flag_bits, input signal_dbm, input antenna_index,
                  input channel_number, output ready);
endinterface

/* design/rthp_seek.sv */
// Next-field search: priority encoder over the pending present bits, then
// alignment and header-length bound. Depends on rthp_pkg.
`timescale 1ns / 1ps

module rthp_seek import rthp_pkg::*; (
  input  rthp_pend_t          pend,
  input  logic [PW_CNT_W-1:0] word_cnt,
  input  logic [15:0]         cur_off,
  input  logic [15:0]         hdr_len,
  output rthp_seek_t          seek
);

  logic [PW_IDX_W-1:0] wsel;
  logic                wany;
  logic [30:0]         wbits;
  logic [4:0]          bsel;
  logic [3:0]          al;
  logic [3:0]          sz;
  logic [17:0]         pos;
  logic [17:0]         apos;
  logic [17:0]         fend;

  // First held word with a pending bit.
  always_comb begin
    wsel = '0;
    wany = 1'b0;
    for (int i = PRES_WORDS - 1; i >= 0; i--) begin
      if ((PW_CNT_W'(i) < word_cnt) && (pend[i] != '0)) begin
        wsel = PW_IDX_W'(i);
        wany = 1'b1;
      end
    end
  end

  // Lowest pending bit of that word.
  always_comb begin
    wbits = pend[wsel];
    bsel  = '0;
    for (int b = 30; b >= 0; b--) begin
      if (wbits[b]) begin
        bsel = 5'(b);
      end
    end
  end

  // Align the next free offset and check the field fits in the header.
  always_comb begin
    al   = fld_align(bsel);
    sz   = fld_size(bsel);
    pos  = {2'b00, cur_off} + 18'd1;
    apos = (pos + {14'd0, al} - 18'd1) & ~({14'd0, al} - 18'd1);
    fend = apos + {14'd0, sz};
    seek.hit      = wany && (bsel < 5'(KNOWN_BITS)) && (fend <= {2'b00, hdr_len});
    seek.word_idx = wsel;
    seek.bit_idx  = bsel;
    seek.fbeg     = apos[15:0];
    seek.fbytes   = sz;
  end

endmodule

/* design/rthp_chan.sv */
// Channel number from the channel frequency in MHz, for the 2.4 and 5 GHz bands.
// Depends on rthp_pkg only by convention; divides by five with a reciprocal multiply.
`timescale 1ns / 1ps

module rthp_chan import rthp_pkg::*; (
  input  logic [15:0]       freq,
  output logic signed [8:0] chan
);

  localparam logic [12:0] RECIP5 = 13'd6554;  // 2^15 / 5, rounded up

  logic        in_2g;
  logic        in_5g;
  logic [9:0]  x;
  logic [22:0] prod;

  // Offset into the band, then quotient by five.
  always_comb begin
    in_2g = (freq >= 16'd2412) && (freq <= 16'd2472);
    in_5g = (freq >= 16'd5000) && (freq <= 16'd5900);
    if (in_2g) begin
      x = 10'(freq - 16'd2407);
    end else begin
      x = 10'(freq - 16'd5000);
    end
    prod = {13'd0, x} * {10'd0, RECIP5};
    if (in_2g || in_5g) begin
      chan = $signed({1'b0, prod[22:15]});
    end else if (freq == 16'd2484) begin
      chan = 9'sd14;
    end else begin
      chan = -9'sd1;
    end
  end

endmodule

/* design/radiotap_header_parser_unit.sv */
// Top level of the radiotap header parser: per-byte state, field capture, result register.
// Depends on rthp_pkg, rthp_if, rthp_seek and rthp_chan.
//
//   channel  | dir | word                         | when
//   in_ch    | in  | data_byte, last_byte         | every frame byte
//   out_ch   | out | parse_ok ... channel_number  | once, on the last byte
//
// One byte is taken per cycle while in_ch.ready is high; each byte updates the packet
// state in the same cycle it is accepted, and the last byte loads the result register.
// The result is available in the cycle after the last byte.
// in_ch.ready drops only while a result waits and out_ch.ready is low.
// Synchronous active-low reset returns to the header phase; no clearing pass.
`timescale 1ns / 1ps

module radiotap_header_parser_unit import rthp_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  rthp_in_if.sink   in_ch,
  rthp_out_if.source out_ch
);

  // Packet state.
  rthp_phase_t         phase_r, phase_nxt;
  logic [15:0]         off_r, off_nxt;
  logic [15:0]         hdr_r, hdr_nxt;
  logic                failed_r, failed_nxt;
  logic [PW_CNT_W-1:0] wcnt_r, wcnt_nxt;
  logic [23:0]         acc_r, acc_nxt;
  rthp_pend_t          pend_r, pend_nxt;
  logic [PW_IDX_W-1:0] cword_r, cword_nxt;
  logic [4:0]          cbit_r, cbit_nxt;
  logic [15:0]         fbeg_r, fbeg_nxt;
  logic [3:0]          fbytes_r, fbytes_nxt;
  logic [4:0]          mask_r, mask_nxt;
  logic [7:0]          flags_r, flags_nxt;
  logic [7:0]          rate_r, rate_nxt;
  logic [31:0]         chw_r, chw_nxt;
  logic [7:0]          sig_r, sig_nxt;
  logic [7:0]          ant_r, ant_nxt;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic                ok_r, ok_nxt;
  logic [15:0]         olen_r, olen_nxt;
  logic [4:0]          omask_r, omask_nxt;
  logic [7:0]          oflags_r, oflags_nxt;
  logic [7:0]          orate_r, orate_nxt;
  logic [31:0]         ochw_r, ochw_nxt;
  logic [7:0]          osig_r, osig_nxt;
  logic [7:0]          oant_r, oant_nxt;
  logic signed [8:0]   ochan_r, ochan_nxt;

  logic                in_fire;
  logic [7:0]          b;
  logic                do_seek;
  logic [31:0]         word;
  logic [16:0]         fend;
  logic                in_field;
  logic [1:0]          fidx;
  rthp_seek_t          seek;
  logic signed [8:0]   chan;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;

  rthp_seek u_seek (
    .pend     (pend_nxt),
    .word_cnt (wcnt_nxt),
    .cur_off  (off_r),
    .hdr_len  (hdr_r),
    .seek     (seek)
  );

  rthp_chan u_chan (
    .freq (chw_nxt[15:0]),
    .chan (chan)
  );

  // Per-byte parse step.
  always_comb begin
    phase_nxt  = phase_r;
    off_nxt    = off_r;
    hdr_nxt    = hdr_r;
    failed_nxt = failed_r;
    wcnt_nxt   = wcnt_r;
    acc_nxt    = acc_r;
    pend_nxt   = pend_r;
    cword_nxt  = cword_r;
    cbit_nxt   = cbit_r;
    fbeg_nxt   = fbeg_r;
    fbytes_nxt = fbytes_r;
    mask_nxt   = mask_r;
    flags_nxt  = flags_r;
    rate_nxt   = rate_r;
    chw_nxt    = chw_r;
    sig_nxt    = sig_r;
    ant_nxt    = ant_r;
    do_seek    = 1'b0;
    word       = {b, acc_r};
    fend       = {1'b0, fbeg_r} + {13'd0, fbytes_r};
    in_field   = ({1'b0, off_r} >= {1'b0, fbeg_r}) && ({1'b0, off_r} < fend);
    fidx       = off_r[1:0] - fbeg_r[1:0];

    if (in_fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (off_r == 16'd0 && b != 8'd0) begin
            failed_nxt = 1'b1;
          end else if (off_r == 16'd2) begin
            hdr_nxt = {8'd0, b};
          end else if (off_r == 16'd3) begin
            hdr_nxt   = {b, hdr_r[7:0]};
            phase_nxt = PH_PRESENT;
          end
        end
        PH_PRESENT: begin
          if (wcnt_r < PW_CNT_W'(PRES_WORDS)) begin
            if (off_r[1:0] == 2'd3) begin
              pend_nxt[wcnt_r[PW_IDX_W-1:0]] = word[30:0];
              wcnt_nxt = wcnt_r + PW_CNT_W'(1);
              if (!(word[31] && (wcnt_nxt < PW_CNT_W'(PRES_WORDS)))) begin
                do_seek = 1'b1;
              end
            end else begin
              acc_nxt[8*off_r[1:0] +: 8] = b;
            end
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        PH_FIELDS: begin
          if (in_field) begin
            // Capture fields of the first present word only.
            if (cword_r == '0) begin
              if (cbit_r == BIT_FLAGS) begin
                flags_nxt   = b;
                mask_nxt[0] = 1'b1;
              end else if (cbit_r == BIT_RATE) begin
                rate_nxt    = b;
                mask_nxt[1] = 1'b1;
              end else if (cbit_r == BIT_CHANNEL) begin
                chw_nxt[8*fidx +: 8] = b;
                mask_nxt[2] = 1'b1;
              end else if (cbit_r == BIT_SIGNAL) begin
                sig_nxt     = b;
                mask_nxt[3] = 1'b1;
              end else if (cbit_r == BIT_ANTENNA) begin
                ant_nxt     = b;
                mask_nxt[4] = 1'b1;
              end
            end
            if ({1'b0, off_r} + 17'd1 == fend) begin
              pend_nxt[cword_r][cbit_r] = 1'b0;
              do_seek = 1'b1;
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      // Move to the next field, or stop.
      if (do_seek) begin
        if (seek.hit) begin
          phase_nxt  = PH_FIELDS;
          cword_nxt  = seek.word_idx;
          cbit_nxt   = seek.bit_idx;
          fbeg_nxt   = seek.fbeg;
          fbytes_nxt = seek.fbytes;
        end else begin
          phase_nxt = PH_DONE;
        end
      end

      if (!in_ch.last_byte && off_r != 16'hFFFF) begin
        off_nxt = off_r + 16'd1;
      end
    end
  end

  // Result word on the last byte, then packet state back to its start.
  always_comb begin
    out_valid_nxt = out_valid_r;
    ok_nxt    = ok_r;
    olen_nxt  = olen_r;
    omask_nxt = omask_r;
    oflags_nxt = oflags_r;
    orate_nxt = orate_r;
    ochw_nxt  = ochw_r;
    osig_nxt  = osig_r;
    oant_nxt  = oant_r;
    ochan_nxt = ochan_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && in_ch.last_byte) begin
      out_valid_nxt = 1'b1;
      ok_nxt = !failed_nxt && (phase_nxt == PH_FIELDS || phase_nxt == PH_DONE) &&
               (hdr_nxt >= 16'd8) && ({1'b0, hdr_nxt} <= {1'b0, off_r} + 17'd1);
      if (ok_nxt) begin
        olen_nxt   = hdr_nxt;
        omask_nxt  = mask_nxt;
        oflags_nxt = flags_nxt;
        orate_nxt  = rate_nxt;
        ochw_nxt   = chw_nxt;
        osig_nxt   = sig_nxt;
        oant_nxt   = ant_nxt;
        ochan_nxt  = chan;
      end else begin
        olen_nxt   = '0;
        omask_nxt  = '0;
        oflags_nxt = '0;
        orate_nxt  = '0;
        ochw_nxt   = '0;
        osig_nxt   = '0;
        oant_nxt   = '0;
        ochan_nxt  = '0;
      end
    end
  end

  // Control and capture state.
  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_ch.last_byte)) begin
      phase_r  <= PH_HEADER;
      off_r    <= '0;
      hdr_r    <= '0;
      failed_r <= 1'b0;
      wcnt_r   <= '0;
      cword_r  <= '0;
      cbit_r   <= '0;
      fbeg_r   <= '0;
      fbytes_r <= '0;
      mask_r   <= '0;
      flags_r  <= '0;
      rate_r   <= '0;
      chw_r    <= '0;
      sig_r    <= '0;
      ant_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      off_r    <= off_nxt;
      hdr_r    <= hdr_nxt;
      failed_r <= failed_nxt;
      wcnt_r   <= wcnt_nxt;
      cword_r  <= cword_nxt;
      cbit_r   <= cbit_nxt;
      fbeg_r   <= fbeg_nxt;
      fbytes_r <= fbytes_nxt;
      mask_r   <= mask_nxt;
      flags_r  <= flags_nxt;
      rate_r   <= rate_nxt;
      chw_r    <= chw_nxt;
      sig_r    <= sig_nxt;
      ant_r    <= ant_nxt;
    end
  end

  // Present words and partial word; read only below the word count.
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    pend_r <= pend_nxt;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    ok_r     <= ok_nxt;
    olen_r   <= olen_nxt;
    omask_r  <= omask_nxt;
    oflags_r <= oflags_nxt;
    orate_r  <= orate_nxt;
    ochw_r   <= ochw_nxt;
    osig_r   <= osig_nxt;
    oant_r   <= oant_nxt;
    ochan_r  <= ochan_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.parse_ok       = ok_r;
  assign out_ch.header_len     = olen_r;
  assign out_ch.found_mask     = omask_r;
  assign out_ch.radio_flags    = oflags_r;
  assign out_ch.rate_units     = orate_r;
  assign out_ch.chan_freq_mhz  = ochw_r[15:0];
  assign out_ch.chan_flag_bits = ochw_r[31:16];
  assign out_ch.signal_dbm     = $signed(osig_r);
  assign out_ch.antenna_index  = oant_r;
  assign out_ch.channel_number = ochan_r;

endmodule

/* dv/tb_radiotap_header_parser_unit.sv */
// Testbench for the radiotap header parser: drives generated frames byte by byte
// and checks each per-frame result against an in-bench parser.
// Depends on rthp_pkg, rthp_if and radiotap_header_parser_unit.
`timescale 1ns / 1ps

module tb_radiotap_header_parser_unit;
  import rthp_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } frame_byte_t;

  typedef struct packed {
    logic              parse_ok;
    logic [15:0]       header_len;
    logic [4:0]        found_mask;
    logic [7:0]        radio_flags;
    logic [7:0]        rate_units;
    logic [15:0]       chan_freq_mhz;
    logic [15:0]       chan_flag_bits;
    logic signed [7:0] signal_dbm;
    logic [7:0]        antenna_index;
    logic signed [8:0] channel_number;
  } parse_result_t;

  // Local phase codes of the in-bench parser.
  typedef enum int {
    P_HEADER, P_PRESENT, P_FIELDS, P_DONE
  } walk_phase_t;

  localparam logic [31:0] EXT_BIT = 32'h8000_0000;

  logic clk;
  logic rst_n;

  rthp_in_if  in_ch ();
  rthp_out_if out_ch ();

  radiotap_header_parser_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  frame_byte_t   byte_queue[$];
  parse_result_t result_queue[$];
  int            mismatch_count;
  int            gap_left;
  int            stall_left;
  int            hold_off;

  // In-bench parser state.
  int          p_off;
  int          p_hlen;
  logic [31:0] p_pres[PRES_WORDS];
  int          p_words;
  int          p_ww;
  int          p_wb;
  int          p_fbeg;
  int          p_fbytes;
  walk_phase_t p_phase;
  logic [63:0] p_vals;
  logic [4:0]  p_mask;
  bit          p_failed;

  function automatic int size_of_bit(int b);
    case (b)
      0: return 8;
      3: return 4;
      4, 7, 8, 9, 14, 15: return 2;
      default: return 1;
    endcase
  endfunction

  function automatic int align_of_bit(int b);
    case (b)
      0: return 8;
      3, 4, 7, 8, 9, 14, 15: return 2;
      default: return 1;
    endcase
  endfunction

  function automatic logic [8:0] channel_of_freq(int f);
    if (f >= 2412 && f <= 2472) return 9'((f - 2407) / 5);
    if (f == 2484) return 9'd14;
    if (f >= 5000 && f <= 5900) return 9'((f - 5000) / 5);
    return 9'h1FF;
  endfunction

  task automatic parser_clear();
    p_off = 0; p_hlen = 0; p_words = 0; p_ww = 0; p_wb = 0;
    p_fbeg = 0; p_fbytes = 0; p_phase = P_HEADER;
    p_vals = '0; p_mask = '0; p_failed = 0;
    for (int i = 0; i < PRES_WORDS; i++) p_pres[i] = '0;
  endtask

  // Find the next set present bit and place its field at or after pos.
  task automatic next_field(int pos);
    int al;
    int sz;
    while (p_ww < p_words) begin
      while (p_wb < 31) begin
        if (p_pres[p_ww][p_wb]) begin
          if (p_wb >= KNOWN_BITS) begin
            p_phase = P_DONE;
            return;
          end
          al = align_of_bit(p_wb);
          sz = size_of_bit(p_wb);
          pos = (pos + al - 1) & ~(al - 1);
          if (pos + sz > p_hlen) begin
            p_phase = P_DONE;
            return;
          end
          p_fbeg = pos; p_fbytes = sz; p_phase = P_FIELDS;
          return;
        end
        p_wb++;
      end
      p_wb = 0;
      p_ww++;
    end
    p_phase = P_DONE;
  endtask

  task automatic capture_byte(int idx, logic [7:0] b);
    if (p_ww != 0) return;
    case (p_wb)
      BIT_FLAGS:   begin p_vals[7:0] = b; p_mask[0] = 1; end
      BIT_RATE:    begin p_vals[15:8] = b; p_mask[1] = 1; end
      BIT_CHANNEL: begin p_vals[16 + 8 * (idx & 3) +: 8] = b; p_mask[2] = 1; end
      BIT_SIGNAL:  begin p_vals[55:48] = b; p_mask[3] = 1; end
      BIT_ANTENNA: begin p_vals[63:56] = b; p_mask[4] = 1; end
      default: ;
    endcase
  endtask

  // Advance the parser by one frame byte; queue a result on the last byte.
  task automatic parse_byte(frame_byte_t fb);
    int lane;
    int off;
    parse_result_t r;
    logic [31:0] w;
    off = p_off;
    case (p_phase)
      P_HEADER: begin
        if (off == 0 && fb.data_byte != 0) p_failed = 1;
        else if (off == 2) p_hlen = fb.data_byte;
        else if (off == 3) begin
          p_hlen |= int'(fb.data_byte) << 8;
          p_phase = P_PRESENT;
        end
      end
      P_PRESENT: begin
        lane = (off - 4) & 3;
        if (p_words < PRES_WORDS) begin
          if (lane == 0) p_pres[p_words] = '0;
          p_pres[p_words][8 * lane +: 8] = fb.data_byte;
          if (lane == 3) begin
            w = p_pres[p_words];
            p_words++;
            if (!((w & EXT_BIT) != 0 && p_words < PRES_WORDS)) next_field(off + 1);
          end
        end else begin
          p_phase = P_DONE;
        end
      end
      P_FIELDS: begin
        if (off >= p_fbeg && off < p_fbeg + p_fbytes) begin
          capture_byte(off - p_fbeg, fb.data_byte);
          if (off == p_fbeg + p_fbytes - 1) begin
            p_wb++;
            next_field(p_fbeg + p_fbytes);
          end
        end
      end
      default: ;
    endcase
    if (!fb.last_byte) begin
      if (p_off < 65535) p_off++;
      return;
    end
    r = '0;
    if (!p_failed && p_phase >= P_FIELDS && p_hlen >= 8 && p_hlen <= off + 1) begin
      r.parse_ok       = 1;
      r.header_len     = p_hlen[15:0];
      r.found_mask     = p_mask;
      r.radio_flags    = p_vals[7:0];
      r.rate_units     = p_vals[15:8];
      r.chan_freq_mhz  = p_vals[31:16];
      r.chan_flag_bits = p_vals[47:32];
      r.signal_dbm     = p_vals[55:48];
      r.antenna_index  = p_vals[63:56];
      r.channel_number = channel_of_freq(int'(p_vals[31:16]));
    end
    result_queue.push_back(r);
    parser_clear();
  endtask

  task automatic push_frame(logic [7:0] bytes[$]);
    frame_byte_t fb;
    for (int i = 0; i < bytes.size(); i++) begin
      fb.data_byte = bytes[i];
      fb.last_byte = (i == bytes.size() - 1);
      byte_queue.push_back(fb);
    end
  endtask

  // Build a frame: given first present word, random further words, loose field bytes, a tail.
  task automatic build_frame(int nwords, logic [31:0] first_word, bit ext_last,
                             int tail, int len_adj);
    logic [7:0]  f[$];
    logic [31:0] wd;
    int          pos;
    int          al;
    int          hlen;
    f = {};
    f.push_back(8'd0); f.push_back(8'($urandom)); f.push_back(8'd0); f.push_back(8'd0);
    pos = 4;
    for (int i = 0; i < nwords; i++) begin
      wd = (i == 0) ? first_word : ($urandom_range(0, 3) == 0 ? $urandom : $urandom & 32'h3_FFFF);
      wd[31] = (i < nwords - 1) ? 1'b1 : ext_last;
      for (int k = 0; k < 4; k++) f.push_back(wd[8 * k +: 8]);
      pos += 4;
    end
    // Field area sized loosely; random bytes cover every bit of the payload.
    for (int i = 0; i < $urandom_range(0, 30); i++) f.push_back(8'($urandom));
    if ($urandom_range(0, 3) == 0) begin
      // Plant a channel frequency, often a valid one, at a likely spot.
      al = $urandom_range(0, 4);
      wd[15:0] = (al == 0) ? 16'(2412 + 5 * $urandom_range(0, 12)) :
                 (al == 1) ? 16'd2484 : (al == 2) ? 16'(5000 + $urandom_range(0, 900)) :
                 16'($urandom);
      f.push_back(wd[7:0]); f.push_back(wd[15:8]);
    end
    hlen = f.size() + len_adj;
    if (hlen < 0) hlen = 0;
    f[2] = hlen[7:0];
    f[3] = hlen[15:8];
    for (int i = 0; i < tail; i++) f.push_back(8'($urandom));
    push_frame(f);
  endtask

  task automatic random_noise_frame();
    logic [7:0] f[$];
    int n;
    f = {};
    n = $urandom_range(1, 14);
    for (int i = 0; i < n; i++) f.push_back($urandom_range(0, 1) ? 8'd0 : 8'($urandom));
    push_frame(f);
  endtask

  // Clock.
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Stimulus: directed frames, then mostly well-formed random frames.
  initial begin
    logic [7:0] f[$];
    rst_n = 0;
    parser_clear();
    // Single-byte frame, nonzero version, short frame.
    f = {8'hFF}; push_frame(f);
    f = {8'h01, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}; push_frame(f);
    f = {8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00}; push_frame(f);
    // Length below 8, length above frame.
    f = {8'h00, 8'h00, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}; push_frame(f);
    f = {8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}; push_frame(f);
    // Minimal header with empty present word.
    f = {8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}; push_frame(f);
    // Flags, rate, channel 2437, signal -128, antenna 0.
    f = {8'h00, 8'h00, 8'h13, 8'h00, 8'h2E, 8'h08, 8'h00, 8'h00,
         8'h10, 8'h02, 8'h85, 8'h09, 8'hA0, 8'h00, 8'h80, 8'h00,
         8'h00, 8'h00, 8'hFF};
    push_frame(f);
    // TSFT with 8-byte alignment, channel 2484 and 5900.
    build_frame(1, 32'h0000_0009, 0, 2, 0);
    f = {8'h00, 8'h00, 8'h0C, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00,
         8'hB4, 8'h09, 8'hFF, 8'hFF};
    push_frame(f);
    f = {8'h00, 8'h00, 8'h0C, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00,
         8'h0C, 8'h17, 8'h00, 8'h00};
    push_frame(f);
    // Unknown bit, overrun, frame ending inside a present word.
    f = {8'h00, 8'h00, 8'h0A, 8'h00, 8'h02, 8'h00, 8'h04, 8'h00, 8'h55, 8'h66}; push_frame(f);
    f = {8'h00, 8'h00, 8'h09, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'h11}; push_frame(f);
    f = {8'h00, 8'h00, 8'h10, 8'h00, 8'h02, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00}; push_frame(f);
    // Word limit: eight words all extended; the walk stops at eight and goes on to the fields.
    build_frame(8, 32'h0000_0806, 1, 3, 0);
    build_frame(3, 32'h8000_082F, 0, 0, 0);
    // Random frames.
    while (byte_queue.size() < 1500) begin
      case ($urandom_range(0, 9))
        0: random_noise_frame();
        1: build_frame($urandom_range(1, 8), $urandom, $urandom_range(0, 1),
                       $urandom_range(0, 4), int'($urandom_range(0, 20)) - 10);
        default: build_frame($urandom_range(0, 4) == 0 ? $urandom_range(2, 8) : 1,
                             ($urandom & 32'h0000_082E) | ($urandom_range(0, 7) == 0 ?
                             $urandom & 32'h7FFF_FFFF : 32'h0),
                             0, $urandom_range(0, 3), 0);
      endcase
    end
    repeat (4) @(posedge clk);
    rst_n <= 1;
    wait (byte_queue.size() == 0);
    wait (result_queue.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Driver: offers the next byte with random gaps.
  initial begin
    in_ch.valid = 0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 0;
    gap_left = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        parse_byte('{in_ch.data_byte, in_ch.last_byte});
        void'(byte_queue.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the offered byte.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 0;
      end else if (byte_queue.size() > 0) begin
        in_ch.valid <= 1;
        in_ch.data_byte <= byte_queue[0].data_byte;
        in_ch.last_byte <= byte_queue[0].last_byte;
        if ($urandom_range(0, 5) == 0)
          gap_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // Receiver stalls: mostly short, a few long, one very long hold-off.
  initial begin
    out_ch.ready = 0;
    stall_left = 0;
    hold_off = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      hold_off <= hold_off + 1;
      if (hold_off >= 200 && hold_off < 600) begin
        out_ch.ready <= 0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
        if ($urandom_range(0, 7) == 0)
          stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
      end
    end
  end

  // Monitor: compare each result word with the oldest expectation.
  initial mismatch_count = 0;

  always @(posedge clk) begin
    parse_result_t got;
    parse_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.parse_ok, out_ch.header_len, out_ch.found_mask, out_ch.radio_flags,
              out_ch.rate_units, out_ch.chan_freq_mhz, out_ch.chan_flag_bits,
              out_ch.signal_dbm, out_ch.antenna_index, out_ch.channel_number};
      if (result_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result word %p", got);
      end else begin
        want = result_queue.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  // Run limit.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
design/rthp_pkg.sv
design/rthp_if.sv
design/rthp_seek.sv
design/rthp_chan.sv
design/radiotap_header_parser_unit.sv
dv/tb_radiotap_header_parser_unit.sv
